FILE: rtl/core/pmv_pkg.sv
// ----------------------------------------------------------------------------
// pmv_pkg
// Shared types and codes for the pneumatic muscle valve controller.
// ----------------------------------------------------------------------------
package pmv_pkg;

  localparam int unsigned PressW    = 32;
  localparam int unsigned CountW    = 8;
  localparam int unsigned RefractW  = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TARGET = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    MODE_HOLD    = 3'd0,
    MODE_ZERO    = 3'd1,
    MODE_INFLATE = 3'd2,
    MODE_DEFLATE = 3'd3,
    MODE_REFRACT = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    DRIVE_OFF   = 2'd0,
    DRIVE_PLUS  = 2'd1,
    DRIVE_MINUS = 2'd3
  } drive_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_REFRACT_TICKS = 2'd0,
    CFG_DROP_LIMIT    = 2'd1
  } cfg_idx_e;

  localparam logic [CountW-1:0] DropLimitReset = 8'd3;
  localparam logic [CountW-1:0] CountMax       = 8'hFF;

  typedef struct packed {
    logic [1:0]               op;
    logic signed [PressW-1:0] value;
    logic                     sample_fresh;
    logic [7:0]               read_error_code;
  } in_item_t;

  typedef struct packed {
    logic                     inflate_valve;
    logic                     deflate_valve;
    logic [2:0]               mode_now;
    logic signed [PressW-1:0] measured_pressure;
    logic                     fault_raise;
    logic [7:0]               fault_code;
    logic [CountW-1:0]        drop_run;
  } out_item_t;

endpackage

FILE: rtl/core/pmv_in_reg.sv
// ----------------------------------------------------------------------------
// pmv_in_reg
// Input register: captures one item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module pmv_in_reg import pmv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  input  logic     take_i,
  output logic     valid_o,
  output in_item_t item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/core/pmv_ctrl.sv
// ----------------------------------------------------------------------------
// pmv_ctrl
// Mode machine, held pressure and target, drop counter and config registers.
// Applies one item per enabled cycle and forms its result.
// ----------------------------------------------------------------------------
module pmv_ctrl import pmv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                en_i,
  input  in_item_t            item_i,
  output out_item_t           result_o
);

  mode_e                    mode_q, mode_d;
  drive_e                   drive_q, drive_d;
  logic signed [PressW-1:0] press_q, press_d;
  logic signed [PressW-1:0] target_q, target_d;
  logic [RefractW-1:0]      refract_q, refract_d;
  logic [CountW-1:0]        drop_q, drop_d;
  logic [RefractW-1:0]      refract_ticks_q;
  logic [CountW-1:0]        drop_limit_q;
  logic                     raise;
  logic [7:0]               code;
  logic                     dropped;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refract_ticks_q <= '0;
      drop_limit_q    <= DropLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REFRACT_TICKS: refract_ticks_q <= cfg_data_i;
        CFG_DROP_LIMIT:    drop_limit_q    <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_HOLD;
      drive_q   <= DRIVE_OFF;
      press_q   <= '0;
      target_q  <= '0;
      refract_q <= '0;
      drop_q    <= '0;
    end else if (en_i) begin
      mode_q    <= mode_d;
      drive_q   <= drive_d;
      press_q   <= press_d;
      target_q  <= target_d;
      refract_q <= refract_d;
      drop_q    <= drop_d;
    end
  end

  assign dropped = item_i.sample_fresh && (item_i.read_error_code != 8'd0);

  always_comb begin
    mode_d    = mode_q;
    drive_d   = drive_q;
    press_d   = press_q;
    target_d  = target_q;
    refract_d = refract_q;
    drop_d    = drop_q;
    raise     = 1'b0;
    code      = 8'd0;
    unique case (op_e'(item_i.op))
      OP_SAMPLE: begin
        if (dropped) begin
          // Saturate the run, keep the old pressure
          drop_d = (drop_q == CountMax) ? drop_q : drop_q + 8'd1;
          if (drop_d >= drop_limit_q) begin
            raise = 1'b1;
            code  = item_i.read_error_code;
          end
        end else begin
          if (item_i.sample_fresh) begin
            drop_d = '0;
          end
          press_d = item_i.value;
        end
      end
      OP_TARGET: begin
        if (item_i.value == '0) begin
          mode_d = MODE_ZERO;
        end else if (mode_q == MODE_HOLD || mode_q == MODE_ZERO) begin
          if (item_i.value < press_q) begin
            mode_d   = MODE_DEFLATE;
            target_d = item_i.value;
          end else if (item_i.value > press_q) begin
            mode_d   = MODE_INFLATE;
            target_d = item_i.value;
          end
        end
      end
      OP_TICK: begin
        unique case (mode_q)
          MODE_ZERO: drive_d = DRIVE_MINUS;
          MODE_INFLATE: begin
            if (target_q < press_q) begin
              mode_d  = MODE_REFRACT;
              drive_d = DRIVE_OFF;
            end else begin
              drive_d = DRIVE_PLUS;
            end
          end
          MODE_DEFLATE: begin
            if (target_q > press_q) begin
              mode_d  = MODE_REFRACT;
              drive_d = DRIVE_OFF;
            end else begin
              drive_d = DRIVE_MINUS;
            end
          end
          MODE_REFRACT: begin
            if (refract_q == refract_ticks_q) begin
              mode_d    = MODE_HOLD;
              refract_d = '0;
            end else begin
              refract_d = refract_q + 16'd1;
            end
          end
          default: ;
        endcase
      end
      OP_NONE: ;
      default: ;
    endcase
  end

  always_comb begin
    result_o.inflate_valve     = (drive_d == DRIVE_PLUS);
    result_o.deflate_valve     = (drive_d == DRIVE_MINUS);
    result_o.mode_now          = mode_d;
    result_o.measured_pressure = press_d;
    result_o.fault_raise       = raise;
    result_o.fault_code        = code;
    result_o.drop_run          = drop_d;
  end

  a_fault_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.fault_raise |-> result_o.fault_code != 8'd0)
    else $error("fault raised without an error code");

  a_drop_only_on_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(en_i && item_i.op == OP_SAMPLE) |=> $stable(drop_q))
    else $error("drop run changed outside a sample item");

  a_refract_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && mode_q != MODE_REFRACT && mode_d == MODE_REFRACT)
      |-> (item_i.op == OP_TICK && drive_d == DRIVE_OFF))
    else $error("refract entered without a tick closing the valves");

endmodule

FILE: rtl/core/pneumatic_muscle_valve_fsm.sv
// ----------------------------------------------------------------------------
// pneumatic_muscle_valve_fsm
// Bang-bang inflate/deflate valve controller for a pneumatic muscle.
// ----------------------------------------------------------------------------
//   channel | handshake                 | payload
//   --------+---------------------------+------------------------------
//   input   | in_valid_i / in_ready_o   | in_item_i  (in_item_t)
//   output  | out_valid_o / out_ready_i | out_item_o (out_item_t)
//   config  | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
// One item per cycle sustained while the output is not stalled; an item's
// result is registered after it passes the input register and then the
// result register. Every item gives exactly one result; the mode update and
// compares sit in combinational logic between the two registers.
// A stalled output holds its result while the input register still takes
// one more item. Reset clears the valid flags and controller state and loads the config defaults.
// ----------------------------------------------------------------------------
module pneumatic_muscle_valve_fsm import pmv_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic      stage_valid;
  in_item_t  stage_item;
  logic      advance;
  out_item_t result;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  // Move an item into the result register when that register is free
  assign advance = stage_valid && (!out_valid_q || out_ready_i);

  pmv_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .take_i     (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  pmv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .en_i       (advance),
    .item_i     (stage_item),
    .result_o   (result)
  );

  assign out_valid_d = advance || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register empty after an item advanced");

  a_stage_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid && !advance) |=> stage_valid)
    else $error("waiting item dropped from input register");

endmodule

FILE: verif/pneumatic_muscle_valve_fsm_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pneumatic_muscle_valve_fsm_tb
// Self-checking bench for the valve controller. A short table of directed
// items covers reset state, field extremes, every op, drop faults and the
// refract round trip. Random phases follow under several register settings:
// control episodes, drop runs, saturation of the drop count, a refract count
// that runs on past a lowered limit, and random noise. Every result is
// compared field by field with its table entry or the in-bench controller model.
// ----------------------------------------------------------------------------
module pneumatic_muscle_valve_fsm_tb;
  import pmv_pkg::*;

  localparam int unsigned CycleLimit    = 4_000_000;
  localparam int unsigned HoldOffCycles = 60;
  localparam int unsigned PhaseItems    = 240;
  localparam int unsigned NumPhases     = 5;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  in_item_t            stim_item  = '0;
  logic                res_valid;
  logic                rx_ready   = 1'b0;
  out_item_t           res_item;
  logic                cfg_we     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx    = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;

  // controller model state
  mode_e                    vm_mode;
  drive_e                   vm_drive;
  logic signed [PressW-1:0] held_press;
  logic signed [PressW-1:0] held_target;
  logic [RefractW-1:0]      refract_cnt;
  logic [CountW-1:0]        drop_cnt;
  logic [RefractW-1:0]      cfg_refract_ticks;
  logic [CountW-1:0]        cfg_drop_limit;

  out_item_t   pending_results [$];
  int unsigned n_items   = 0;
  int unsigned n_checked = 0;
  int unsigned n_faults  = 0;
  int unsigned n_fail    = 0;
  int unsigned n_cycles  = 0;
  bit          idle_on   = 1'b1;
  bit          hold_off_req = 1'b0;

  pneumatic_muscle_valve_fsm i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (stim_item),
    .out_valid_o (res_valid),
    .out_ready_i (rx_ready),
    .out_item_o  (res_item),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // Apply one item to the model state and return the result it gives.
  function automatic out_item_t valve_step(in_item_t it);
    out_item_t                res;
    logic                     raise;
    logic [7:0]               code;
    logic signed [PressW-1:0] v;
    raise = 1'b0;
    code  = '0;
    v     = $signed(it.value);
    case (it.op)
      OP_SAMPLE: begin
        if (it.sample_fresh && it.read_error_code != 8'd0) begin
          if (drop_cnt != CountMax) drop_cnt = drop_cnt + 1'b1;
          if (drop_cnt >= cfg_drop_limit) begin
            raise = 1'b1;
            code  = it.read_error_code;
          end
        end else begin
          if (it.sample_fresh) drop_cnt = '0;
          held_press = v;
        end
      end
      OP_TARGET: begin
        if (v == 0) begin
          vm_mode = MODE_ZERO;
        end else if (vm_mode == MODE_HOLD || vm_mode == MODE_ZERO) begin
          if (v < held_press) begin
            vm_mode     = MODE_DEFLATE;
            held_target = v;
          end else if (v > held_press) begin
            vm_mode     = MODE_INFLATE;
            held_target = v;
          end
        end
      end
      OP_TICK: begin
        case (vm_mode)
          MODE_ZERO: vm_drive = DRIVE_MINUS;
          MODE_INFLATE: begin
            if (held_target < held_press) begin
              vm_mode  = MODE_REFRACT;
              vm_drive = DRIVE_OFF;
            end else begin
              vm_drive = DRIVE_PLUS;
            end
          end
          MODE_DEFLATE: begin
            if (held_target > held_press) begin
              vm_mode  = MODE_REFRACT;
              vm_drive = DRIVE_OFF;
            end else begin
              vm_drive = DRIVE_MINUS;
            end
          end
          MODE_REFRACT: begin
            if (refract_cnt == cfg_refract_ticks) begin
              vm_mode     = MODE_HOLD;
              refract_cnt = '0;
            end else begin
              refract_cnt = refract_cnt + 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    res.inflate_valve     = (vm_drive == DRIVE_PLUS);
    res.deflate_valve     = (vm_drive == DRIVE_MINUS);
    res.mode_now          = vm_mode;
    res.measured_pressure = held_press;
    res.fault_raise       = raise;
    res.fault_code        = code;
    res.drop_run          = drop_cnt;
    return res;
  endfunction

  function automatic in_item_t mk_item(op_e op, logic [31:0] v, logic fresh,
                                       logic [7:0] err);
    in_item_t it;
    it.op              = op;
    it.value           = v;
    it.sample_fresh    = fresh;
    it.read_error_code = err;
    return it;
  endfunction

  function automatic out_item_t mk_res(logic inf, logic def, mode_e m,
                                       logic [31:0] p, logic raise,
                                       logic [7:0] code, logic [7:0] drops);
    out_item_t r;
    r.inflate_valve     = inf;
    r.deflate_valve     = def;
    r.mode_now          = m;
    r.measured_pressure = p;
    r.fault_raise       = raise;
    r.fault_code        = code;
    r.drop_run          = drops;
    return r;
  endfunction

  function automatic dir_row_t mk_row(in_item_t stim, bit typed = 1'b0,
                                      out_item_t want = '0);
    dir_row_t r;
    r.stim  = stim;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // Mostly small Q16.16 pressures, now and then full range or an extreme.
  function automatic int pick_pressure();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return int'($urandom_range(0, 32'h10_0000)) - 32'h8_0000;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want,
                                      logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endfunction

  // Offer one item; entered and left at a falling edge, valid left high.
  task automatic offer_item(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    out_item_t predicted;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    stim_item <= it;
    do @(posedge clk_i); while (!in_ready);
    predicted = valve_step(it);
    pending_results.push_back(typed ? want : predicted);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write both registers on back-to-back cycles; block must be idle.
  task automatic program_cfg(logic [15:0] ticks, logic [7:0] limit);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_REFRACT_TICKS;
    cfg_data <= ticks;
    @(negedge clk_i);
    cfg_idx  <= CFG_DROP_LIMIT;
    cfg_data <= {8'd0, limit};
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    cfg_refract_ticks = ticks;
    cfg_drop_limit    = limit;
  endtask

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    out_item_t got;
    if (rst_ni && res_valid && rx_ready) begin
      got = res_item;
      if (pending_results.size() == 0) begin
        $error("result with no item pending: 0x%0h", got);
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        check_field("inflate_valve", 32'(want.inflate_valve),
                    32'(got.inflate_valve));
        check_field("deflate_valve", 32'(want.deflate_valve),
                    32'(got.deflate_valve));
        check_field("mode_now", 32'(want.mode_now), 32'(got.mode_now));
        check_field("measured_pressure", want.measured_pressure,
                    got.measured_pressure);
        check_field("fault_raise", 32'(want.fault_raise), 32'(got.fault_raise));
        check_field("fault_code", 32'(want.fault_code), 32'(got.fault_code));
        check_field("drop_run", 32'(want.drop_run), 32'(got.drop_run));
        n_checked++;
        if (got.fault_raise) n_faults++;
      end
    end
  end

  initial begin : rx_side
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rx_ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
        rx_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rx_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
        rx_ready <= 1'b1;
      end else begin
        rx_ready <= 1'b1;
      end
    end
  end

  initial begin : stim_side
    dir_row_t    dir_rows [$];
    logic [15:0] ph_ticks [NumPhases];
    logic [7:0]  ph_limit [NumPhases];
    int unsigned phase_start;
    int unsigned len;
    int          pr;
    int          tg;

    vm_mode           = MODE_HOLD;
    vm_drive          = DRIVE_OFF;
    held_press        = '0;
    held_target       = '0;
    refract_cnt       = '0;
    drop_cnt          = '0;
    cfg_refract_ticks = '0;
    cfg_drop_limit    = DropLimitReset;

    // refract ticks never decrease across these phases, so a leftover
    // refract count cannot exceed the new limit
    ph_ticks = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd5};
    ph_limit = '{8'd1, 8'd0, 8'd2, 8'd255, 8'd4};

    dir_rows.push_back(mk_row(mk_item(OP_NONE, 32'hFFFF_FFFF, 1'b1, 8'hFF), 1'b1,
                              mk_res(1'b0, 1'b0, MODE_HOLD, 32'h0, 1'b0, 8'h00,
                                     8'd0)));
    dir_rows.push_back(mk_row(mk_item(OP_TICK, 32'h0, 1'b0, 8'h00), 1'b1,
                              mk_res(1'b0, 1'b0, MODE_HOLD, 32'h0, 1'b0, 8'h00,
                                     8'd0)));
    dir_rows.push_back(mk_row(mk_item(OP_SAMPLE, 32'h7FFF_FFFF, 1'b1, 8'h00), 1'b1,
                              mk_res(1'b0, 1'b0, MODE_HOLD, 32'h7FFF_FFFF, 1'b0,
                                     8'h00, 8'd0)));
    dir_rows.push_back(mk_row(mk_item(OP_TARGET, 32'h8000_0000, 1'b0, 8'h00), 1'b1,
                              mk_res(1'b0, 1'b0, MODE_DEFLATE, 32'h7FFF_FFFF, 1'b0,
                                     8'h00, 8'd0)));
    dir_rows.push_back(mk_row(mk_item(OP_TICK, 32'h0, 1'b0, 8'h00), 1'b1,
                              mk_res(1'b0, 1'b1, MODE_DEFLATE, 32'h7FFF_FFFF, 1'b0,
                                     8'h00, 8'd0)));
    dir_rows.push_back(mk_row(mk_item(OP_TARGET, 32'h0, 1'b1, 8'h00), 1'b1,
                              mk_res(1'b0, 1'b1, MODE_ZERO, 32'h7FFF_FFFF, 1'b0,
                                     8'h00, 8'd0)));
    dir_rows.push_back(mk_row(mk_item(OP_TICK, 32'h0, 1'b0, 8'h00), 1'b1,
                              mk_res(1'b0, 1'b1, MODE_ZERO, 32'h7FFF_FFFF, 1'b0,
                                     8'h00, 8'd0)));
    dir_rows.push_back(mk_row(mk_item(OP_SAMPLE, 32'h8000_0000, 1'b1, 8'h00)));
    dir_rows.push_back(mk_row(mk_item(OP_TARGET, 32'h0001_0000, 1'b0, 8'h00)));
    dir_rows.push_back(mk_row(mk_item(OP_TICK, 32'h0, 1'b0, 8'h00)));
    // nonzero target while inflating: ignored
    dir_rows.push_back(mk_row(mk_item(OP_TARGET, 32'h0000_0005, 1'b0, 8'h00)));
    dir_rows.push_back(mk_row(mk_item(OP_SAMPLE, 32'h1234_5678, 1'b1, 8'h01)));
    dir_rows.push_back(mk_row(mk_item(OP_SAMPLE, 32'h1234_5678, 1'b1, 8'h80)));
    dir_rows.push_back(mk_row(mk_item(OP_SAMPLE, 32'h1234_5678, 1'b1, 8'hFF), 1'b1,
                              mk_res(1'b1, 1'b0, MODE_INFLATE, 32'h8000_0000, 1'b1,
                                     8'hFF, 8'd3)));
    // stale sample with an error code: taken, drop run kept
    dir_rows.push_back(mk_row(mk_item(OP_SAMPLE, 32'h7FFF_FFFF, 1'b0, 8'h42)));
    dir_rows.push_back(mk_row(mk_item(OP_TICK, 32'h0, 1'b1, 8'h00)));
    dir_rows.push_back(mk_row(mk_item(OP_TICK, 32'h0, 1'b0, 8'h00)));
    dir_rows.push_back(mk_row(mk_item(OP_SAMPLE, 32'h0002_8000, 1'b1, 8'h00)));
    // target equal to the held pressure leaves the mode alone
    dir_rows.push_back(mk_row(mk_item(OP_TARGET, 32'h0002_8000, 1'b0, 8'h00)));
    dir_rows.push_back(mk_row(mk_item(OP_TARGET, 32'hFFFF_0000, 1'b0, 8'h00)));
    dir_rows.push_back(mk_row(mk_item(OP_TICK, 32'h0, 1'b0, 8'h00)));
    dir_rows.push_back(mk_row(mk_item(OP_SAMPLE, 32'hFFFE_0000, 1'b1, 8'h00)));
    dir_rows.push_back(mk_row(mk_item(OP_TICK, 32'h0, 1'b0, 8'h00)));
    dir_rows.push_back(mk_row(mk_item(OP_TICK, 32'h0, 1'b0, 8'h00)));
    dir_rows.push_back(mk_row(mk_item(OP_NONE, 32'h0, 1'b0, 8'h00)));

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) offer_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    drain_results();

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph == NumPhases - 1) begin
        // refract limit lowered below a running count: the count runs on
        program_cfg(16'hFFFF, 8'd3);
        offer_item(mk_item(OP_TARGET, 32'h0, 1'b0, 8'h00));
        offer_item(mk_item(OP_SAMPLE, 32'h0001_0000, 1'b1, 8'h00));
        offer_item(mk_item(OP_TARGET, 32'h0002_0000, 1'b0, 8'h00));
        offer_item(mk_item(OP_SAMPLE, 32'h0003_0000, 1'b1, 8'h00));
        repeat (13) offer_item(mk_item(OP_TICK, $urandom, 1'b0, 8'h00));
        drain_results();
        program_cfg(16'd4, 8'd3);
        repeat (6) offer_item(mk_item(OP_TICK, 32'h0, 1'b0, 8'h00));
        drain_results();
        // raise the limit just above the count so the refract ends
        program_cfg(16'd24, 8'd3);
        while (vm_mode == MODE_REFRACT) offer_item(mk_item(OP_TICK, 32'h0, 1'b0, 8'h00));
        drain_results();
        idle_on = 1'b0;
      end
      program_cfg(ph_ticks[ph], ph_limit[ph]);
      if (ph == 0) hold_off_req = 1'b1;
      if (ph_limit[ph] == 8'd255) begin
        // long drop run: reach the limit, then hold at saturation
        repeat (260) offer_item(mk_item(OP_SAMPLE, $urandom, 1'b1,
                                        8'($urandom_range(1, 255))));
      end
      phase_start = n_items;
      while (n_items - phase_start < PhaseItems) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            pr = pick_pressure();
            offer_item(mk_item(OP_SAMPLE, pr, 1'b1, 8'h00));
            case ($urandom_range(0, 7))
              0:       tg = 0;
              1:       tg = pr;
              2:       tg = pick_pressure();
              default: tg = pr + int'($urandom_range(0, 32'h4_0000)) - 32'h2_0000;
            endcase
            offer_item(mk_item(OP_TARGET, tg, 1'($urandom_range(0, 1)),
                               8'($urandom)));
            repeat ($urandom_range(4, 16)) begin
              if ($urandom_range(0, 2) == 0) begin
                pr = tg + int'($urandom_range(0, 32'h2_0000)) - 32'h1_0000;
                offer_item(mk_item(OP_SAMPLE, pr, $urandom_range(0, 4) != 0,
                                   8'(($urandom_range(0, 9) == 0) ?
                                      $urandom_range(1, 255) : 0)));
              end else begin
                offer_item(mk_item(OP_TICK, $urandom, 1'($urandom_range(0, 1)),
                                   8'($urandom)));
              end
            end
            // run out the refract count
            repeat (cfg_refract_ticks + 2) offer_item(mk_item(OP_TICK, $urandom, 1'b0, 8'h00));
          end
          5, 6: begin
            len = (cfg_drop_limit > 8'd10) ? $urandom_range(1, 12)
                                           : $urandom_range(1, cfg_drop_limit + 2);
            repeat (len) begin
              if ($urandom_range(0, 5) == 0) begin
                offer_item(mk_item(OP_SAMPLE, pick_pressure(), 1'b0, 8'($urandom)));
              end else begin
                offer_item(mk_item(OP_SAMPLE, $urandom, 1'b1,
                                   8'($urandom_range(1, 255))));
              end
            end
          end
          default: begin
            repeat ($urandom_range(1, 5)) begin
              offer_item(mk_item(op_e'($urandom_range(0, 3)), $urandom,
                                 1'($urandom_range(0, 1)), 8'($urandom)));
            end
          end
        endcase
      end
      drain_results();
    end

    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      n_fail++;
    end
    $display("Ran %0d items, checked %0d results, %0d drop faults seen.",
             n_items, n_checked, n_faults);
    $display("Settings swept refract ticks 0..65535 with a lowered limit, drop limit 0..255.");
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
